>>> rtl/gb7_pkg.sv
package gb7_pkg;

  // Default sizes and kernel geometry
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int WEIGHT_FRAC_DEF = 16;
  localparam int KSIZE           = 7;
  localparam int KHALF           = 3;
  localparam int STORE_LINES     = 6;
  localparam int PIX_W           = 8;
  localparam int COUNT_W         = 10;
  localparam int SIZE_W          = 11;
  localparam int COUNT_LIMIT     = 1024;
  localparam int RESET_WIDTH     = 640;
  localparam int RESET_HEIGHT    = 480;

  // Pixels that share one weight are summed before the multiply
  localparam int NUM_GROUPS  = 10;
  localparam int GROUP_SUM_W = 11;

  // Result buffer
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [KSIZE-1:0][KSIZE-1:0] window_t;

  typedef struct packed {
    logic [COUNT_W-1:0] row;
    logic [COUNT_W-1:0] column;
    logic               last;
  } pos_t;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

  // Weights in millionths, ordered by (lo, hi) offset pair:
  // (0,0) (0,1) (0,2) (0,3) (1,1) (1,2) (1,3) (2,2) (2,3) (3,3)
  localparam int GROUP_MILLIONTHS [NUM_GROUPS] = '{
    146768, 92651, 23226, 2291, 58488, 14662, 1446, 3676, 363, 36
  };

  function automatic int offset_of(int i);
    return (i >= KHALF) ? i - KHALF : KHALF - i;
  endfunction

  function automatic int group_of(int k, int l);
    int a;
    int b;
    int lo;
    int hi;
    int grp;
    a  = offset_of(k);
    b  = offset_of(l);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (lo * 4 + hi)
      0:       grp = 0;
      1:       grp = 1;
      2:       grp = 2;
      3:       grp = 3;
      5:       grp = 4;
      6:       grp = 5;
      7:       grp = 6;
      10:      grp = 7;
      11:      grp = 8;
      15:      grp = 9;
      default: grp = 0;
    endcase
    return grp;
  endfunction

  // Round half up to frac fractional bits
  function automatic longint fixed_weight(int g, int frac);
    longint scaled;
    scaled = longint'(GROUP_MILLIONTHS[g]) << frac;
    return (scaled + 64'sd500000) / 64'sd1000000;
  endfunction

endpackage

>>> rtl/gb7_line_store.sv
module gb7_line_store #(
  parameter int MAX_WIDTH = gb7_pkg::MAX_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                   rd_addr,
  output logic [gb7_pkg::STORE_LINES*gb7_pkg::PIX_W-1:0] rd_data,
  input  logic                                           wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]                   wr_addr,
  input  logic [gb7_pkg::STORE_LINES*gb7_pkg::PIX_W-1:0] wr_data
);
  import gb7_pkg::*;

  localparam int LINE_W = STORE_LINES * PIX_W;

  // One word per column holds that column of all six stored rows
  logic [LINE_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // forward a same-column write from the previous pixel
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> rtl/gb7_kernel.sv
module gb7_kernel #(
  parameter int WEIGHT_FRAC_BITS = gb7_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  gb7_pkg::window_t      window,
  input  gb7_pkg::pos_t         in_pos,
  output logic                  out_valid,
  output logic [7:0]            out_value,
  output gb7_pkg::pos_t         out_pos
);
  import gb7_pkg::*;

  localparam int WW   = WEIGHT_FRAC_BITS - 1;
  localparam int PW   = GROUP_SUM_W + WW;
  localparam int HALF = NUM_GROUPS / 2;

  logic [GROUP_SUM_W-1:0] gsum_c [NUM_GROUPS];
  logic [GROUP_SUM_W-1:0] gsum_q [NUM_GROUPS];
  logic [PW-1:0]          prod_q [NUM_GROUPS];
  logic [PW-1:0]          half_c [2];
  logic [PW-1:0]          half_q [2];
  logic [PW-1:0]          total_q;
  logic                   v1, v2, v3, v4;
  pos_t                   p1, p2, p3, p4;

  // Sum the pixels that share a weight
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      gsum_c[g] = '0;
      for (int k = 0; k < KSIZE; k++) begin
        for (int l = 0; l < KSIZE; l++) begin
          if (group_of(k, l) == g) begin
            gsum_c[g] = gsum_c[g] + GROUP_SUM_W'(window[k][l]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      gsum_q <= gsum_c;
      p1     <= in_pos;
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_prod
    localparam logic [WW-1:0] WEIGHT = WW'(fixed_weight(g, WEIGHT_FRAC_BITS));
    always_ff @(posedge clk) begin
      if (v1) begin
        prod_q[g] <= PW'(gsum_q[g]) * PW'(WEIGHT);
      end
    end
  end

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      half_c[h] = '0;
      for (int i = 0; i < HALF; i++) begin
        half_c[h] = half_c[h] + prod_q[h * HALF + i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      p2 <= p1;
    end
    if (v2) begin
      half_q <= half_c;
      p3     <= p2;
    end
    if (v3) begin
      total_q <= half_q[0] + half_q[1];
      p4      <= p3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Drop the fraction, saturate at 255
  assign out_value = (total_q[PW-1:WEIGHT_FRAC_BITS+8] != '0) ? 8'hFF :
                     total_q[WEIGHT_FRAC_BITS+7:WEIGHT_FRAC_BITS];
  assign out_valid = v4;
  assign out_pos   = p4;

endmodule

>>> rtl/gaussian_blur_7x7.sv
// 7x7 Gaussian smoothing of an 8-bit grey stream. Pixels enter in raster order, one per
// clock when out_ready keeps up; frame_start on a pixel makes it row 0, column 0, and the
// position counters also wrap by themselves at the end of each frame. A result appears
// only for pixels at least three from every edge, tagged with its row and column and
// with last_of_frame on the final interior pixel; border pixels give no transaction.
// A result can be taken once the pixel that completes its window has gone through the
// line store read (one read and one write port, a word per column holding the six
// previous rows), the 7x7 window shift, the weighting pipeline (shared-weight sums,
// ten constant multiplies, two adder levels, each registered), and the write into
// the result buffer, in that order. An eight-entry result buffer decouples the output;
// in_ready drops only while eight results are owed downstream, so with out_ready held
// high at most seven are owed and a pixel is taken every cycle. Both ready outputs are
// low during reset. image_width and image_height (written at index 0 and 1 of the
// config port) are clamped to 7..1024 (width also to MAX_WIDTH) and must be written
// while no frame is in flight. The line store is not cleared after reset; the first six
// rows of a frame fill it before any result reads it.
module gaussian_blur_7x7 #(
  parameter int MAX_WIDTH        = gb7_pkg::MAX_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = gb7_pkg::WEIGHT_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   pixel_value,
  input  logic                         frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   smoothed_value,
  output logic [9:0]                   out_row,
  output logic [9:0]                   out_column,
  output logic                         last_of_frame,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  gb7_pkg::cfg_index_t          cfg_index,
  input  logic [gb7_pkg::SIZE_W-1:0]   cfg_data
);
  import gb7_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WMAX   = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
  localparam int LINE_W = STORE_LINES * PIX_W;
  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] value;
    pos_t       pos;
  } result_t;

  // Clamp a size to 7..hi and return size - 1
  function automatic logic [COUNT_W-1:0] size_last(logic [SIZE_W-1:0] v, int hi);
    logic [COUNT_W-1:0] res;
    if (v < SIZE_W'(KSIZE)) begin
      res = COUNT_W'(KSIZE - 1);
    end else if (32'(v) > hi) begin
      res = COUNT_W'(hi - 1);
    end else begin
      res = COUNT_W'(v - SIZE_W'(1));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  logic [COUNT_W-1:0] w_last;
  logic [COUNT_W-1:0] h_last;

  // hold off register writes during reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= COUNT_W'(RESET_WIDTH - 1);
      h_last <= COUNT_W'(RESET_HEIGHT - 1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= size_last(cfg_data, WMAX);
        REG_IMAGE_HEIGHT: h_last <= size_last(cfg_data, COUNT_LIMIT);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side
  logic               accept;
  logic [COUNT_W-1:0] row_count, col_count;
  logic [COUNT_W-1:0] row_next, col_next;
  logic [COUNT_W-1:0] r0, c0;
  logic               emit_c;
  logic               last_c;
  logic [AW-1:0]      rd_addr;

  assign accept = in_valid && in_ready;

  // frame_start restarts the position before this pixel is placed
  assign r0 = frame_start ? '0 : row_count;
  assign c0 = frame_start ? '0 : col_count;

  assign emit_c = (r0 >= COUNT_W'(KSIZE - 1)) && (c0 >= COUNT_W'(KSIZE - 1));
  assign last_c = (r0 >= h_last) && (c0 >= w_last);

  assign rd_addr = ({22'd0, c0} >= 32'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : AW'(c0);

  always_comb begin
    if (c0 >= w_last) begin
      col_next = '0;
      row_next = (r0 >= h_last) ? '0 : r0 + COUNT_W'(1);
    end else begin
      col_next = c0 + COUNT_W'(1);
      row_next = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  // Stage 1: pixel is held while the line store read is registered
  logic          s1_valid;
  logic [7:0]    s1_pixel;
  logic [AW-1:0] s1_addr;
  logic          s1_emit;
  pos_t          s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel      <= pixel_value;
      s1_addr       <= rd_addr;
      s1_emit       <= emit_c;
      s1_pos.row    <= r0 - COUNT_W'(KHALF);
      s1_pos.column <= c0 - COUNT_W'(KHALF);
      s1_pos.last   <= last_c;
    end
  end

  // ---------------------------------------------------------------- line store
  logic [LINE_W-1:0] rd_line;
  logic [LINE_W-1:0] wr_line;
  pix_t              column_c [KSIZE];

  gb7_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_line),
    .wr_en   (s1_valid),
    .wr_addr (s1_addr),
    .wr_data (wr_line)
  );

  // New window column: six stored rows, oldest first, then the new pixel.
  // Each stored row moves up one place on write-back.
  always_comb begin
    for (int k = 0; k < STORE_LINES; k++) begin
      column_c[k] = rd_line[k*PIX_W +: PIX_W];
    end
    column_c[KSIZE-1] = s1_pixel;
    for (int k = 0; k < STORE_LINES; k++) begin
      wr_line[k*PIX_W +: PIX_W] = column_c[k+1];
    end
  end

  // ---------------------------------------------------------------- window
  window_t win;
  logic    wv_valid;
  pos_t    wv_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      wv_valid <= 1'b0;
    end else begin
      wv_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int k = 0; k < KSIZE; k++) begin
          for (int l = 0; l < KSIZE - 1; l++) begin
            win[k][l] <= win[k][l+1];
          end
          win[k][KSIZE-1] <= column_c[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      wv_pos <= s1_pos;
    end
  end

  // ---------------------------------------------------------------- weighting
  logic       k_valid;
  logic [7:0] k_value;
  pos_t       k_pos;

  gb7_kernel #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_kernel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wv_valid),
    .window    (win),
    .in_pos    (wv_pos),
    .out_valid (k_valid),
    .out_value (k_value),
    .out_pos   (k_pos)
  );

  // ---------------------------------------------------------------- result buffer
  result_t              fifo_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] head, tail;
  logic [PEND_W-1:0]    fifo_count;
  logic [PEND_W-1:0]    pending;
  logic                 push, pop;
  result_t              head_res;

  assign push = k_valid;
  assign pop  = out_valid && out_ready;

  // pending counts results owed downstream, in flight or buffered;
  // holding it at the buffer depth keeps the buffer from overflowing
  assign in_ready = !rst && (pending < PEND_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      fifo_count <= '0;
      head       <= '0;
      tail       <= '0;
    end else begin
      pending    <= pending + PEND_W'(accept && emit_c) - PEND_W'(pop);
      fifo_count <= fifo_count + PEND_W'(push) - PEND_W'(pop);
      if (push) begin
        tail <= tail + OUT_PTR_W'(1);
      end
      if (pop) begin
        head <= head + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[tail] <= '{value: k_value, pos: k_pos};
    end
  end

  assign head_res       = fifo_mem[head];
  assign out_valid      = (fifo_count != '0);
  assign smoothed_value = head_res.value;
  assign out_row        = head_res.pos.row;
  assign out_column     = head_res.pos.column;
  assign last_of_frame  = head_res.pos.last;

  // ---------------------------------------------------------------- checks
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(OUT_DEPTH))
    else $error("owed result count exceeds buffer depth");

  a_buffer_within_pending: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= pending)
    else $error("buffer holds more results than are owed");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    k_valid |-> (fifo_count != PEND_W'(OUT_DEPTH)))
    else $error("result arrived with buffer full");

  a_pending_tracks_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && emit_c && !pop) |=> (pending == $past(pending) + PEND_W'(1)))
    else $error("owed result count missed an accepted interior pixel");

endmodule
